[design/spcp_pkg.sv]
`timescale 1ns / 1ps
package spcp_pkg;

    localparam int UTTERANCE_MAX = 64;
    localparam int IDX_W = $clog2(UTTERANCE_MAX);
    localparam int LEN_W = IDX_W + 1;

    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    localparam int SPD_W = 4;
    localparam int PIT_W = 7;
    localparam int VOL_W = 4;
    localparam int VAL_W = 7;

    localparam logic [SPD_W-1:0] SPEED_MAX   = 4'd9;
    localparam logic [PIT_W-1:0] PITCH_MAX   = 7'd99;
    localparam logic [VOL_W-1:0] VOLUME_MAX  = 4'd9;
    localparam logic [SPD_W-1:0] SPEED_DEF   = 4'd5;
    localparam logic [PIT_W-1:0] PITCH_DEF   = 7'd50;
    localparam logic [VOL_W-1:0] VOLUME_DEF  = 4'd5;
    localparam logic [VAL_W-1:0] VALUE_CAP   = 7'd100;
    localparam logic [7:0]       THRESH_DEF  = 8'd2;

    // Input modes.
    localparam logic [1:0] MODE_BYTE  = 2'd0;
    localparam logic [1:0] MODE_POLL  = 2'd1;
    localparam logic [1:0] MODE_ABORT = 2'd2;

    // Characters with a meaning of their own.
    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_CMD   = 8'h01;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_FLUSH = 8'h18;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_QUEST = 8'h3F;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_AT    = 8'h40;
    localparam logic [7:0] CH_UP_S  = 8'h53;
    localparam logic [7:0] CH_LO_S  = 8'h73;
    localparam logic [7:0] CH_UP_P  = 8'h50;
    localparam logic [7:0] CH_LO_P  = 8'h70;
    localparam logic [7:0] CH_UP_V  = 8'h56;
    localparam logic [7:0] CH_LO_V  = 8'h76;

    // Register map.
    localparam logic REG_IDLE_THRESHOLD = 1'b0;

    // Operations passed from the front to the back.
    localparam logic [3:0] OP_APPEND  = 4'd0;
    localparam logic [3:0] OP_SPEAK   = 4'd1;
    localparam logic [3:0] OP_DISCARD = 4'd2;
    localparam logic [3:0] OP_POLL    = 4'd3;
    localparam logic [3:0] OP_SPEED   = 4'd4;
    localparam logic [3:0] OP_PITCH   = 4'd5;
    localparam logic [3:0] OP_VOLUME  = 4'd6;
    localparam logic [3:0] OP_RESTORE = 4'd7;
    localparam logic [3:0] OP_NOCHG   = 4'd8;

    typedef struct packed {
        logic [3:0] code;
        logic [7:0] data;
    } op_t;

    function automatic logic is_term(input logic [7:0] ch);
        return (ch == CH_DOT) || (ch == CH_QUEST) || (ch == CH_BANG);
    endfunction

endpackage

[design/spcp_if.sv]
`timescale 1ns / 1ps
interface spcp_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic [7:0] data_byte;
    logic [7:0] idle_ticks;

    modport source (output valid, output mode, output data_byte, output idle_ticks,
                    input ready);
    modport sink (input valid, input mode, input data_byte, input idle_ticks,
                  output ready);
endinterface

interface spcp_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] text_byte;
    logic       last;
    logic [3:0] speed;
    logic [6:0] pitch;
    logic [3:0] volume;

    modport source (output valid, output kind, output text_byte, output last,
                    output speed, output pitch, output volume, input ready);
    modport sink (input valid, input kind, input text_byte, input last,
                  input speed, input pitch, input volume, output ready);
endinterface

[design/spcp_ram.sv]
`timescale 1ns / 1ps
module spcp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

[design/spcp_front.sv]
`timescale 1ns / 1ps
module spcp_front
    import spcp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [1:0] mode,
    input  logic [7:0] data_byte,
    input  logic       q_full,
    output logic       q_push,
    output op_t        q_op
);

    logic             in_command_reg, in_command_next;
    logic [VAL_W-1:0] value_reg, value_next;
    logic             seen_reg, seen_next;

    logic             accept;
    logic             is_digit;
    logic [10:0]      scaled;
    logic [VAL_W-1:0] cmd_val;
    logic             has_op;
    op_t              op;

    assign in_ready = !q_full;
    assign accept   = in_valid && in_ready;
    assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);

    // value * 10 + digit, the digit being the low nibble of an ASCII numeral.
    assign scaled = ({4'b0, value_reg} << 3) + ({4'b0, value_reg} << 1)
                  + {7'b0, data_byte[3:0]};
    assign cmd_val = seen_reg ? value_reg : '0;

    always_comb
    begin
        in_command_next = in_command_reg;
        value_next      = value_reg;
        seen_next       = seen_reg;
        has_op          = 1'b0;
        op.code         = OP_NOCHG;
        op.data         = '0;
        unique case (mode)
            MODE_ABORT:
            begin
                in_command_next = 1'b0;
                has_op          = 1'b1;
                op.code         = OP_DISCARD;
            end
            MODE_POLL:
            begin
                has_op  = 1'b1;
                op.code = OP_POLL;
                op.data = '0;
            end
            MODE_BYTE:
            begin
                if (in_command_reg)
                begin
                    if (is_digit)
                    begin
                        value_next = (scaled > {4'b0, VALUE_CAP}) ? VALUE_CAP
                                                                   : scaled[VAL_W-1:0];
                        seen_next  = 1'b1;
                    end
                    else
                    begin
                        in_command_next = 1'b0;
                        has_op          = 1'b1;
                        if (data_byte == CH_UP_S || data_byte == CH_LO_S)
                        begin
                            op.code = OP_SPEED;
                            op.data = (cmd_val > {3'b0, SPEED_MAX}) ? {4'b0, SPEED_MAX}
                                                                    : {1'b0, cmd_val};
                        end
                        else if (data_byte == CH_UP_P || data_byte == CH_LO_P)
                        begin
                            op.code = OP_PITCH;
                            op.data = (cmd_val > PITCH_MAX) ? {1'b0, PITCH_MAX}
                                                            : {1'b0, cmd_val};
                        end
                        else if (data_byte == CH_UP_V || data_byte == CH_LO_V)
                        begin
                            op.code = OP_VOLUME;
                            op.data = (cmd_val > {3'b0, VOLUME_MAX}) ? {4'b0, VOLUME_MAX}
                                                                     : {1'b0, cmd_val};
                        end
                        else if (data_byte == CH_AT)
                        begin
                            op.code = OP_RESTORE;
                        end
                        else
                        begin
                            op.code = OP_NOCHG;
                        end
                    end
                end
                else if (data_byte == CH_CMD)
                begin
                    in_command_next = 1'b1;
                    value_next      = '0;
                    seen_next       = 1'b0;
                end
                else if (data_byte == CH_FLUSH)
                begin
                    has_op  = 1'b1;
                    op.code = OP_DISCARD;
                end
                else if (data_byte == CH_CR || data_byte == CH_LF || data_byte == CH_NUL)
                begin
                    has_op  = 1'b1;
                    op.code = OP_SPEAK;
                end
                else if (data_byte >= CH_SPACE)
                begin
                    has_op  = 1'b1;
                    op.code = OP_APPEND;
                    op.data = data_byte;
                end
            end
            default:
            begin
                has_op = 1'b0;
            end
        endcase
    end

    assign q_push = accept && has_op;
    assign q_op   = op;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_command_reg <= 1'b0;
            value_reg      <= '0;
            seen_reg       <= 1'b0;
        end
        else if (accept)
        begin
            in_command_reg <= in_command_next;
            value_reg      <= value_next;
            seen_reg       <= seen_next;
        end
    end

endmodule

[design/spcp_queue.sv]
`timescale 1ns / 1ps
module spcp_queue
    import spcp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  op_t  push_op,
    output logic full,
    output logic avail,
    output op_t  head_op,
    input  logic pop
);

    op_t               entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;

    logic do_push;
    logic do_pop;

    assign full    = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign avail   = (count_reg != '0);
    assign head_op = entry_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && avail;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

[design/spcp_back.sv]
`timescale 1ns / 1ps
module spcp_back
    import spcp_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [7:0]       idle_threshold,
    input  logic             q_avail,
    input  op_t              q_op,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic             out_kind,
    output logic [7:0]       out_text,
    output logic             out_last,
    output logic [SPD_W-1:0] out_speed,
    output logic [PIT_W-1:0] out_pitch,
    output logic [VOL_W-1:0] out_volume
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RD   = 2'd1;
    localparam logic [1:0] ST_SEND = 2'd2;

    logic [1:0]       state_reg, state_next;
    logic [LEN_W-1:0] len_reg, len_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [SPD_W-1:0] speed_reg, speed_next;
    logic [PIT_W-1:0] pitch_reg, pitch_next;
    logic [VOL_W-1:0] volume_reg, volume_next;

    logic             out_valid_reg;
    logic             out_kind_reg;
    logic [7:0]       out_text_reg;
    logic             out_last_reg;
    logic [SPD_W-1:0] out_speed_reg;
    logic [PIT_W-1:0] out_pitch_reg;
    logic [VOL_W-1:0] out_volume_reg;

    logic             can_load;
    logic             load;
    logic             ld_kind;
    logic [7:0]       ld_text;
    logic             ld_last;
    logic             ram_we;
    logic             ram_re;
    logic [7:0]       ram_rdata;
    logic             has_room;
    logic [LEN_W-1:0] grown_len;
    logic             at_end;

    assign can_load  = !out_valid_reg || out_ready;
    assign has_room  = (len_reg < LEN_W'(UTTERANCE_MAX));
    assign grown_len = has_room ? (len_reg + 1'b1) : len_reg;
    assign at_end    = (({1'b0, idx_reg} + 1'b1) == len_reg);

    spcp_ram #(
        .WIDTH (8),
        .DEPTH (UTTERANCE_MAX)
    ) u_buf (
        .clk   (clk),
        .we    (ram_we),
        .waddr (len_reg[IDX_W-1:0]),
        .wdata (q_op.data),
        .re    (ram_re),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        speed_next  = speed_reg;
        pitch_next  = pitch_reg;
        volume_next = volume_reg;
        q_pop       = 1'b0;
        ram_we      = 1'b0;
        ram_re      = 1'b0;
        load        = 1'b0;
        ld_kind     = 1'b1;
        ld_text     = '0;
        ld_last     = 1'b1;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (q_avail)
                begin
                    unique case (q_op.code) inside
                        OP_APPEND:
                        begin
                            q_pop    = 1'b1;
                            ram_we   = has_room;
                            len_next = grown_len;
                            if (is_term(q_op.data) || grown_len == LEN_W'(UTTERANCE_MAX))
                            begin
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        OP_SPEAK:
                        begin
                            q_pop = 1'b1;
                            if (len_reg != '0)
                            begin
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        OP_DISCARD:
                        begin
                            q_pop    = 1'b1;
                            len_next = '0;
                        end
                        OP_POLL:
                        begin
                            q_pop = 1'b1;
                            if (len_reg != '0 && q_op.data >= idle_threshold)
                            begin
                                idx_next   = '0;
                                state_next = ST_RD;
                            end
                        end
                        OP_SPEED, OP_PITCH, OP_VOLUME, OP_RESTORE, OP_NOCHG:
                        begin
                            // A parameter update waits for the output register.
                            if (can_load)
                            begin
                                q_pop = 1'b1;
                                load  = 1'b1;
                                if (q_op.code == OP_SPEED)
                                begin
                                    speed_next = q_op.data[SPD_W-1:0];
                                end
                                else if (q_op.code == OP_PITCH)
                                begin
                                    pitch_next = q_op.data[PIT_W-1:0];
                                end
                                else if (q_op.code == OP_VOLUME)
                                begin
                                    volume_next = q_op.data[VOL_W-1:0];
                                end
                                else if (q_op.code == OP_RESTORE)
                                begin
                                    speed_next  = SPEED_DEF;
                                    pitch_next  = PITCH_DEF;
                                    volume_next = VOLUME_DEF;
                                end
                            end
                        end
                        default:
                        begin
                            q_pop = 1'b1;
                        end
                    endcase
                end
            end
            ST_RD:
            begin
                ram_re     = 1'b1;
                state_next = ST_SEND;
            end
            ST_SEND:
            begin
                if (can_load)
                begin
                    load    = 1'b1;
                    ld_kind = 1'b0;
                    ld_text = ram_rdata;
                    ld_last = at_end;
                    if (at_end)
                    begin
                        len_next   = '0;
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            len_reg       <= '0;
            idx_reg       <= '0;
            speed_reg     <= SPEED_DEF;
            pitch_reg     <= PITCH_DEF;
            volume_reg    <= VOLUME_DEF;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            len_reg    <= len_next;
            idx_reg    <= idx_next;
            speed_reg  <= speed_next;
            pitch_reg  <= pitch_next;
            volume_reg <= volume_next;
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_kind_reg   <= ld_kind;
            out_text_reg   <= ld_text;
            out_last_reg   <= ld_last;
            out_speed_reg  <= speed_next;
            out_pitch_reg  <= pitch_next;
            out_volume_reg <= volume_next;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_kind   = out_kind_reg;
    assign out_text   = out_text_reg;
    assign out_last   = out_last_reg;
    assign out_speed  = out_speed_reg;
    assign out_pitch  = out_pitch_reg;
    assign out_volume = out_volume_reg;

    a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
        len_reg <= LEN_W'(UTTERANCE_MAX))
        else $error("utterance length beyond buffer size");

    a_speak_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_RD || state_reg == ST_SEND) |-> ({1'b0, idx_reg} < len_reg))
        else $error("read index outside the pending utterance");

    a_param_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg) |-> out_last_reg)
        else $error("parameter update without last mark");

    a_settings_range: assert property (@(posedge clk) disable iff (!rst_n)
        speed_reg <= SPEED_MAX && pitch_reg <= PITCH_MAX && volume_reg <= VOLUME_MAX)
        else $error("speech settings out of range");

endmodule

[design/speech_command_stream_parser.sv]
`timescale 1ns / 1ps
// A parameter update passes through the queue and the output register, waiting while
// that register holds an output not yet taken. Text runs: each byte is read from the
// single utterance buffer by a registered read, then sent; no queue pop comes until
// the run ends. Operations enter the two-entry queue at one per cycle unless it is full.
// Reset clears the parser and queue and sets speed 5, pitch 50, volume 5, threshold 2.
module speech_command_stream_parser
    import spcp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    spcp_in_if.sink     in_chan,
    spcp_out_if.source  out_chan,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [7:0] threshold_reg;
    logic       q_push;
    op_t        push_op;
    logic       q_full;
    logic       q_avail;
    op_t        head_op;
    logic       q_pop;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_IDLE_THRESHOLD) ? {24'b0, threshold_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESH_DEF;
        end
        else if (psel && penable && pwrite && pready && paddr[2] == REG_IDLE_THRESHOLD)
        begin
            threshold_reg <= pwdata[7:0];
        end
    end

    spcp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_chan.valid),
        .in_ready  (in_chan.ready),
        .mode      (in_chan.mode),
        .data_byte (in_chan.data_byte),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_op      (push_op)
    );

    // The idle poll carries its tick count in the operation data.
    op_t front_op;
    always_comb
    begin
        front_op = push_op;
        if (push_op.code == OP_POLL)
        begin
            front_op.data = in_chan.idle_ticks;
        end
    end

    spcp_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .push_op (front_op),
        .full    (q_full),
        .avail   (q_avail),
        .head_op (head_op),
        .pop     (q_pop)
    );

    spcp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .idle_threshold (threshold_reg),
        .q_avail        (q_avail),
        .q_op           (head_op),
        .q_pop          (q_pop),
        .out_valid      (out_chan.valid),
        .out_ready      (out_chan.ready),
        .out_kind       (out_chan.kind),
        .out_text       (out_chan.text_byte),
        .out_last       (out_chan.last),
        .out_speed      (out_chan.speed),
        .out_pitch      (out_chan.pitch),
        .out_volume     (out_chan.volume)
    );

endmodule

[tb/sv/speech_command_stream_parser_test.sv]
`timescale 1ns / 1ps
module speech_command_stream_parser_test;
    import spcp_pkg::*;

    localparam logic       KIND_TEXT   = 1'b0;
    localparam logic       KIND_PARAM  = 1'b1;
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [2:0] ADDR_IDLE_THRESHOLD = {REG_IDLE_THRESHOLD, 2'b00};
    localparam int         DRAIN_CYCLES    = 20;
    localparam int         HOLD_OFF_CYCLES = 400;

    typedef struct packed {
        logic             kind;
        logic [7:0]       text_byte;
        logic             last;
        logic [SPD_W-1:0] speed;
        logic [PIT_W-1:0] pitch;
        logic [VOL_W-1:0] volume;
    } speech_out_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    spcp_in_if  in_chan ();
    spcp_out_if out_chan ();

    speech_command_stream_parser dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (in_chan),
        .out_chan (out_chan),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Parser state as the block should hold it.
    logic [7:0]       utter_buf [UTTERANCE_MAX];
    int unsigned      utter_len;
    bit               cmd_open;
    int unsigned      cmd_value;
    logic [SPD_W-1:0] cur_speed;
    logic [PIT_W-1:0] cur_pitch;
    logic [VOL_W-1:0] cur_volume;
    logic [7:0]       idle_limit;

    speech_out_t queued_speech [$];
    int          mismatch_count = 0;
    int          burst_left = 0;
    int          stall_cycles = 0;

    function automatic string describe(input speech_out_t r);
        return $sformatf("kind %0d byte 0x%02h last %0d speed %0d pitch %0d volume %0d",
                         r.kind, r.text_byte, r.last, r.speed, r.pitch, r.volume);
    endfunction

    function automatic void push_speech(input logic k, input logic [7:0] ch, input logic l);
        speech_out_t r;
        r.kind      = k;
        r.text_byte = ch;
        r.last      = l;
        r.speed     = cur_speed;
        r.pitch     = cur_pitch;
        r.volume    = cur_volume;
        queued_speech.push_back(r);
    endfunction

    function automatic void speak_utterance();
        for (int i = 0; i < utter_len; i++)
            push_speech(KIND_TEXT, utter_buf[i], i == utter_len - 1);
        utter_len = 0;
    endfunction

    function automatic void close_command(input logic [7:0] ch);
        cmd_open = 1'b0;
        case (ch) inside
            CH_UP_S, CH_LO_S: cur_speed  = (cmd_value > SPEED_MAX)  ? SPEED_MAX  : cmd_value[3:0];
            CH_UP_P, CH_LO_P: cur_pitch  = (cmd_value > PITCH_MAX)  ? PITCH_MAX  : cmd_value[6:0];
            CH_UP_V, CH_LO_V: cur_volume = (cmd_value > VOLUME_MAX) ? VOLUME_MAX : cmd_value[3:0];
            CH_AT:
            begin
                cur_speed  = SPEED_DEF;
                cur_pitch  = PITCH_DEF;
                cur_volume = VOLUME_DEF;
            end
            default: ;
        endcase
        push_speech(KIND_PARAM, 8'h00, 1'b1);
    endfunction

    function automatic void predict_item(input logic [1:0] m, input logic [7:0] ch,
                                         input logic [7:0] ticks);
        case (m)
            MODE_ABORT:
            begin
                utter_len = 0;
                cmd_open  = 1'b0;
            end
            MODE_POLL:
            begin
                if (utter_len != 0 && ticks >= idle_limit)
                    speak_utterance();
            end
            MODE_BYTE:
            begin
                if (cmd_open) begin
                    if (ch >= CH_ZERO && ch <= CH_NINE) begin
                        cmd_value = cmd_value * 10 + (ch - CH_ZERO);
                        if (cmd_value > VALUE_CAP)
                            cmd_value = VALUE_CAP;
                    end
                    else
                        close_command(ch);
                end
                else if (ch == CH_CMD) begin
                    cmd_open  = 1'b1;
                    cmd_value = 0;
                end
                else if (ch == CH_FLUSH)
                    utter_len = 0;
                else if (ch == CH_CR || ch == CH_LF || ch == CH_NUL)
                    speak_utterance();
                else if (ch >= CH_SPACE) begin
                    if (utter_len < UTTERANCE_MAX) begin
                        utter_buf[utter_len] = ch;
                        utter_len++;
                    end
                    if (ch == CH_DOT || ch == CH_QUEST || ch == CH_BANG
                        || utter_len >= UTTERANCE_MAX)
                        speak_utterance();
                end
            end
            default: ;
        endcase
    endfunction

    function automatic logic [7:0] rand_printable();
        return 8'($urandom_range(CH_SPACE, 8'hFF));
    endfunction

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        #5_000_000;
        $display("speech_command_stream_parser_test NOT OK");
        $finish;
    end

    // Receiver: segments of steady, light, heavy or alternating stalls, plus a long
    // hold-off whenever a test asks for one.
    initial begin
        int seg_left;
        int style;
        seg_left = 0;
        style = 0;
        out_chan.ready <= 1'b0;
        forever begin
            @(posedge clk);
            if (seg_left == 0) begin
                seg_left = $urandom_range(10, 80);
                style = $urandom_range(0, 3);
            end
            seg_left--;
            if (stall_cycles > 0) begin
                stall_cycles--;
                out_chan.ready <= 1'b0;
            end
            else begin
                case (style)
                    0: out_chan.ready <= 1'b1;
                    1: out_chan.ready <= ($urandom_range(0, 3) != 0);
                    2: out_chan.ready <= ($urandom_range(0, 3) == 0);
                    default: out_chan.ready <= seg_left[0];
                endcase
            end
        end
    end

    always @(posedge clk) begin
        speech_out_t seen;
        speech_out_t want;
        if (rst_n && out_chan.valid && out_chan.ready) begin
            seen = {out_chan.kind, out_chan.text_byte, out_chan.last,
                    out_chan.speed, out_chan.pitch, out_chan.volume};
            if (queued_speech.size() == 0) begin
                if (mismatch_count < 10)
                    $display("%t unexpected output: %s", $realtime, describe(seen));
                mismatch_count++;
            end
            else begin
                want = queued_speech.pop_front();
                if (seen.kind !== want.kind || seen.text_byte !== want.text_byte
                    || seen.last !== want.last || seen.speed !== want.speed
                    || seen.pitch !== want.pitch || seen.volume !== want.volume) begin
                    if (mismatch_count < 10)
                        $display("%t output mismatch: expected %s, got %s",
                                 $realtime, describe(want), describe(seen));
                    mismatch_count++;
                end
            end
        end
    end

    // Valid stays high from one item to the next inside a burst.
    task automatic send_item(input logic [1:0] m, input logic [7:0] ch,
                             input logic [7:0] ticks);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 16);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0) begin
                in_chan.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_chan.valid      <= 1'b1;
        in_chan.mode       <= m;
        in_chan.data_byte  <= ch;
        in_chan.idle_ticks <= ticks;
        do @(posedge clk); while (!in_chan.ready);
        predict_item(m, ch, ticks);
    endtask

    task automatic send_byte(input logic [7:0] ch);
        send_item(MODE_BYTE, ch, 8'($urandom));
    endtask

    task automatic send_poll(input logic [7:0] ticks);
        send_item(MODE_POLL, 8'($urandom), ticks);
    endtask

    task automatic wait_idle();
        in_chan.valid <= 1'b0;
        burst_left = 0;
        while (queued_speech.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Writes the threshold, then reads it straight back.
    task automatic write_idle_threshold(input logic [7:0] value);
        logic [31:0] rd;
        wait_idle();
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_IDLE_THRESHOLD;
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        idle_limit = value;
        if (rd[7:0] !== value) begin
            if (mismatch_count < 10)
                $display("%t threshold read back 0x%02h, expected 0x%02h",
                         $realtime, rd[7:0], value);
            mismatch_count++;
        end
    endtask

    task automatic test_commands();
        // 123 saturates at the cap and the speed is then clamped to its maximum.
        send_byte(CH_CMD);
        send_byte("1");
        send_byte("2");
        send_byte("3");
        send_byte(CH_UP_S);
        // No digits means zero.
        send_byte(CH_CMD);
        send_byte(CH_LO_P);
        send_byte(CH_CMD);
        send_byte("4");
        send_byte(CH_LO_V);
        send_byte(CH_CMD);
        send_byte(CH_AT);
        // A control byte closes the command without changing anything.
        send_byte(CH_CMD);
        send_byte(CH_CR);
    endtask

    task automatic test_utterances();
        send_byte("H");
        send_byte(CH_BANG);
        send_byte(8'hFF);
        send_byte(CH_SPACE);
        send_byte(8'h1B);
        send_byte(CH_LF);
        send_byte("A");
        send_byte(CH_FLUSH);
        send_byte(CH_NUL);
        send_byte(CH_QUEST);
    endtask

    task automatic test_idle_and_abort();
        send_byte("B");
        send_poll(8'd1);
        send_poll(8'd2);
        // The abort drops the open command, so the S that follows is plain text.
        send_byte(CH_CMD);
        send_byte("7");
        send_item(MODE_ABORT, 8'($urandom), 8'($urandom));
        send_byte(CH_UP_S);
        send_item(MODE_UNUSED, 8'($urandom), 8'($urandom));
        send_byte(CH_DOT);
    endtask

    task automatic test_thresholds();
        write_idle_threshold(8'd0);
        send_byte("X");
        send_poll(8'd0);
        write_idle_threshold(8'd255);
        send_byte("Y");
        send_poll(8'd254);
        send_poll(8'd255);
    endtask

    task automatic test_random_traffic(input int n_items);
        int sent;
        int pick;
        int len;
        logic [7:0] ch;
        logic [1:0] m;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 45) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(50, 70)
                                                   : $urandom_range(1, 10);
                repeat (len) send_byte(rand_printable());
                sent += len + 1;
                case ($urandom_range(0, 9))
                    0: send_byte(CH_DOT);
                    1: send_byte(CH_QUEST);
                    2: send_byte(CH_BANG);
                    3: send_byte(CH_CR);
                    4: send_byte(CH_LF);
                    5: send_byte(CH_NUL);
                    6: send_poll(8'($urandom));
                    7: send_byte(CH_FLUSH);
                    8: send_item(MODE_ABORT, 8'($urandom), 8'($urandom));
                    default: sent--;
                endcase
            end
            else if (pick < 75) begin
                len = $urandom_range(0, 3);
                send_byte(CH_CMD);
                repeat (len) send_byte(8'(CH_ZERO + $urandom_range(0, 9)));
                sent += len + 2;
                case ($urandom_range(0, 10))
                    0: ch = CH_UP_S;
                    1: ch = CH_LO_S;
                    2: ch = CH_UP_P;
                    3: ch = CH_LO_P;
                    4: ch = CH_UP_V;
                    5: ch = CH_LO_V;
                    6: ch = CH_AT;
                    default: ch = 8'($urandom);
                endcase
                if ($urandom_range(0, 9) == 0)
                    send_item(MODE_ABORT, ch, 8'($urandom));
                else
                    send_byte(ch);
            end
            else if (pick < 90) begin
                // Half the polls land right around the threshold.
                if ($urandom_range(0, 1) == 0)
                    send_poll(8'($urandom));
                else
                    send_poll(8'(idle_limit - 1 + $urandom_range(0, 2)));
                sent++;
            end
            else begin
                m = 2'($urandom);
                send_item(m, 8'($urandom), 8'($urandom));
                if (m != MODE_UNUSED)
                    sent++;
            end
        end
    endtask

    task automatic test_full_buffer();
        logic [7:0] ch;
        repeat (UTTERANCE_MAX + 6) begin
            do ch = rand_printable(); while (ch == CH_DOT || ch == CH_QUEST || ch == CH_BANG);
            send_byte(ch);
        end
        send_byte(CH_CR);
    endtask

    task automatic test_backpressure();
        stall_cycles = HOLD_OFF_CYCLES;
        repeat (40) send_byte(rand_printable());
        send_byte(CH_DOT);
        send_byte(CH_CMD);
        send_byte("8");
        send_byte(CH_UP_V);
        repeat (12) send_byte(rand_printable());
        send_byte(CH_LF);
    endtask

    initial begin
        rst_n                <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        in_chan.valid        <= 1'b0;
        in_chan.mode         <= MODE_BYTE;
        in_chan.data_byte    <= 8'h00;
        in_chan.idle_ticks   <= 8'h00;
        utter_len  = 0;
        cmd_open   = 1'b0;
        cmd_value  = 0;
        cur_speed  = SPEED_DEF;
        cur_pitch  = PITCH_DEF;
        cur_volume = VOLUME_DEF;
        idle_limit = THRESH_DEF;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        test_commands();
        test_utterances();
        test_idle_and_abort();
        test_thresholds();
        test_random_traffic(25);
        write_idle_threshold(8'($urandom_range(1, 254)));
        test_random_traffic(25);
        test_full_buffer();
        write_idle_threshold(8'd0);
        test_random_traffic(25);
        write_idle_threshold(THRESH_DEF);
        test_backpressure();
        write_idle_threshold(8'($urandom_range(1, 254)));
        test_random_traffic(25);

        wait_idle();
        if (mismatch_count == 0 && queued_speech.size() == 0)
            $display("speech_command_stream_parser_test OK");
        else
            $display("speech_command_stream_parser_test NOT OK");
        $finish;
    end

endmodule
